@@ rtl/brfsw_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package brfsw_pkg;

    // operation codes carried on func
    typedef enum logic [2:0] {
        FUNC_WRITE      = 3'd0,
        FUNC_SPEC_WRITE = 3'd1,
        FUNC_READ       = 3'd2,
        FUNC_ADV_READ   = 3'd3,
        FUNC_ADV_WRITE  = 3'd4,
        FUNC_ADV_SPEC   = 3'd5,
        FUNC_SYNC_SPEC  = 3'd6,
        FUNC_RESET      = 3'd7
    } func_t;

    localparam int unsigned FUNC_W   = 3;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned FIELD_W  = 12;

endpackage

`default_nettype wire

@@ rtl/byte_ring_fifo_speculative_write.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Byte ring buffer of DEPTH entries (a power of two) with a read pointer, a committed
// write pointer and a speculative write pointer; one slot is always left empty. Each
// input word selects one operation through func and yields exactly one output word that
// reports the spaces and contiguous lengths after the operation. One word is taken per
// clock unless the output stalls: every operation makes at most one access to the
// single-port byte store, the pointers update at the edge the word is taken, and the
// store's registered read data and the registered status form the output word. A word
// is thus delivered in the cycle after it is taken, and the input stays ready while
// the output is being taken or empty. The store needs no clearing after reset; reading
// a byte that was never written returns an undefined value.
module byte_ring_fifo_speculative_write
    import brfsw_pkg::*;
#(
    parameter int unsigned DEPTH = 4096
) (
    input  wire logic                clk,
    input  wire logic                rst_n,

    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [FUNC_W-1:0]   func,
    input  wire logic [BYTE_W-1:0]   data_in,
    input  wire logic [FIELD_W-1:0]  count,

    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [BYTE_W-1:0]        read_data,
    output logic                     accepted,
    output logic [FIELD_W-1:0]       read_space,
    output logic [FIELD_W-1:0]       write_space,
    output logic [FIELD_W-1:0]       spec_write_space,
    output logic [FIELD_W-1:0]       read_contig,
    output logic [FIELD_W-1:0]       write_contig
);

    localparam int unsigned AW = $clog2(DEPTH);

    // pointers and output stage
    logic [AW-1:0]      rd_ptr_reg,   rd_ptr_next;
    logic [AW-1:0]      wr_ptr_reg,   wr_ptr_next;
    logic [AW-1:0]      spec_ptr_reg, spec_ptr_next;
    logic               out_valid_reg;
    logic               rd_ok_reg;
    logic               acc_reg,      acc_next;
    logic [FIELD_W-1:0] rs_reg,   rs_next;
    logic [FIELD_W-1:0] ws_reg,   ws_next;
    logic [FIELD_W-1:0] sws_reg,  sws_next;
    logic [FIELD_W-1:0] rc_reg,   rc_next;
    logic [FIELD_W-1:0] wc_reg,   wc_next;

    // byte store
    logic [BYTE_W-1:0]  mem [DEPTH];
    logic [BYTE_W-1:0]  mem_rdata_reg;

    logic               in_fire;
    func_t              op;
    logic [AW+FIELD_W-1:0] count_wide;
    logic [AW-1:0]      count_mod;
    logic [AW-1:0]      used_cur;
    logic [AW-1:0]      free_wr_cur;
    logic [AW-1:0]      free_spec_cur;
    logic               do_wr, do_spec_wr, do_rd;
    logic [AW-1:0]      mem_waddr;

    logic [AW-1:0]      rs_n, ws_n, sws_n;
    logic [AW:0]        rd_room, wr_room;
    logic [AW:0]        rc_n, wc_n;
    logic [AW+FIELD_W:0] rs_w, ws_w, sws_w, rc_w, wc_w;

    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;
    assign op       = func_t'(func);

    // count modulo depth
    assign count_wide = {{AW{1'b0}}, count};
    assign count_mod  = count_wide[AW-1:0];

    // spaces before the operation
    assign used_cur      = wr_ptr_reg - rd_ptr_reg;
    assign free_wr_cur   = rd_ptr_reg - wr_ptr_reg - AW'(1);
    assign free_spec_cur = rd_ptr_reg - spec_ptr_reg - AW'(1);

    assign do_wr      = in_fire && (op == FUNC_WRITE) && (free_wr_cur != '0);
    assign do_spec_wr = in_fire && (op == FUNC_SPEC_WRITE) && (free_spec_cur != '0);
    assign do_rd      = in_fire && (op == FUNC_READ) && (used_cur != '0);
    assign mem_waddr  = (op == FUNC_SPEC_WRITE) ? spec_ptr_reg : wr_ptr_reg;

    // pointer update per operation
    always_comb
    begin
        rd_ptr_next   = rd_ptr_reg;
        wr_ptr_next   = wr_ptr_reg;
        spec_ptr_next = spec_ptr_reg;
        acc_next      = 1'b0;
        case (op)
            FUNC_WRITE:
            begin
                if (free_wr_cur != '0)
                begin
                    wr_ptr_next = wr_ptr_reg + AW'(1);
                    acc_next    = 1'b1;
                end
            end
            FUNC_SPEC_WRITE:
            begin
                if (free_spec_cur != '0)
                begin
                    spec_ptr_next = spec_ptr_reg + AW'(1);
                    acc_next      = 1'b1;
                end
            end
            FUNC_READ:
            begin
                if (used_cur != '0)
                begin
                    rd_ptr_next = rd_ptr_reg + AW'(1);
                    acc_next    = 1'b1;
                end
            end
            FUNC_ADV_READ:  rd_ptr_next   = rd_ptr_reg + count_mod;
            FUNC_ADV_WRITE: wr_ptr_next   = wr_ptr_reg + count_mod;
            FUNC_ADV_SPEC:  spec_ptr_next = spec_ptr_reg + count_mod;
            FUNC_SYNC_SPEC: spec_ptr_next = wr_ptr_reg;
            FUNC_RESET:
            begin
                rd_ptr_next = '0;
                wr_ptr_next = '0;
            end
            default:
            begin
                rd_ptr_next = '0;
                wr_ptr_next = '0;
            end
        endcase
    end

    // status after the operation
    always_comb
    begin
        rs_n    = wr_ptr_next - rd_ptr_next;
        ws_n    = rd_ptr_next - wr_ptr_next - AW'(1);
        sws_n   = rd_ptr_next - spec_ptr_next - AW'(1);
        rd_room = (AW+1)'(DEPTH) - {1'b0, rd_ptr_next};
        wr_room = (AW+1)'(DEPTH) - {1'b0, wr_ptr_next};
        rc_n    = ({1'b0, rs_n} < rd_room) ? {1'b0, rs_n} : rd_room;
        wc_n    = ({1'b0, ws_n} < wr_room) ? {1'b0, ws_n} : wr_room;
        rs_w    = {{(FIELD_W+1){1'b0}}, rs_n};
        ws_w    = {{(FIELD_W+1){1'b0}}, ws_n};
        sws_w   = {{(FIELD_W+1){1'b0}}, sws_n};
        rc_w    = {{FIELD_W{1'b0}}, rc_n};
        wc_w    = {{FIELD_W{1'b0}}, wc_n};
        rs_next  = rs_w[FIELD_W-1:0];
        ws_next  = ws_w[FIELD_W-1:0];
        sws_next = sws_w[FIELD_W-1:0];
        rc_next  = rc_w[FIELD_W-1:0];
        wc_next  = wc_w[FIELD_W-1:0];
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg    <= '0;
            wr_ptr_reg    <= '0;
            spec_ptr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                rd_ptr_reg    <= rd_ptr_next;
                wr_ptr_reg    <= wr_ptr_next;
                spec_ptr_reg  <= spec_ptr_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // output word payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            rd_ok_reg <= do_rd;
            acc_reg   <= acc_next;
            rs_reg    <= rs_next;
            ws_reg    <= ws_next;
            sws_reg   <= sws_next;
            rc_reg    <= rc_next;
            wc_reg    <= wc_next;
        end
    end

    // byte store, at most one access per word
    always_ff @(posedge clk)
    begin
        if (do_wr || do_spec_wr)
        begin
            mem[mem_waddr] <= data_in;
        end
        if (do_rd)
        begin
            mem_rdata_reg <= mem[rd_ptr_reg];
        end
    end

    assign out_valid        = out_valid_reg;
    assign read_data        = rd_ok_reg ? mem_rdata_reg : '0;
    assign accepted         = acc_reg;
    assign read_space       = rs_reg;
    assign write_space      = ws_reg;
    assign spec_write_space = sws_reg;
    assign read_contig      = rc_reg;
    assign write_contig     = wc_reg;

    // a taken byte write moves the committed pointer by one
    a_write_step: assert property (@(posedge clk) disable iff (!rst_n)
        do_wr |=> (wr_ptr_reg == $past(wr_ptr_reg) + AW'(1)))
        else $error("committed pointer did not step after write");

    // reset word clears read and write but keeps the speculative pointer
    a_reset_keep_spec: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && (op == FUNC_RESET)) |=>
            (rd_ptr_reg == '0) && (wr_ptr_reg == '0)
            && (spec_ptr_reg == $past(spec_ptr_reg)))
        else $error("reset word pointer update wrong");

    // read data is only non-zero on a successful read
    a_rdata_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !accepted) |-> (read_data == '0))
        else $error("read data without accepted access");

    // a word is never lost while the output stalls
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> !in_ready)
        else $error("input taken while output word stalled");

endmodule

`default_nettype wire
